// ===== rtl/core/cjvl_pkg.sv =====
// Package for the corner junction velocity limit block.
// Holds payload structs, register indexes, field widths and the
// command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package cjvl_pkg;

  localparam int NumAxes     = 6;
  localparam int UnitW       = 16;
  localparam int LenW        = 32;
  localparam int SpeedW      = 32;
  localparam int LimitW      = 48;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLimitX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLimitZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLimitA = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLimitB = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLimitC = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWindow = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgFloor  = 3'd7;

  localparam logic [LenW-1:0]  WindowReset = 32'd32768;
  localparam logic [UnitW-1:0] FloorReset  = 16'd1;

  // Input item operation codes.
  localparam logic OpMove = 1'b0;
  localparam logic OpEnd  = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic signed [UnitW-1:0] unit_a;
    logic signed [UnitW-1:0] unit_b;
    logic signed [UnitW-1:0] unit_c;
    logic [5:0]              axis_mask;
    logic [LenW-1:0]         move_length;
    logic [SpeedW-1:0]       abs_vmax;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] corner_speed;
    logic              to_stop;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic load_first;
    logic init;
    logic div_load;
    logic div_step;
    logic apply_q;
    logic axis_next;
    logic commit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic held_valid;
    logic is_end;
    logic hit;
    logic sat;
    logic div_last;
    logic axis_last;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cjvl_ctrl.sv =====
// Controller state machine for the corner junction velocity limit block.
// Sequences capture, per-axis evaluation, division and commit; uses cjvl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cjvl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cjvl_pkg::status_t status_i,
  output cjvl_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SAxis  = 3'd2;
  localparam logic [2:0] SDiv   = 3'd3;
  localparam logic [2:0] SApply = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;

  // Input is taken only while nothing is in flight.
  assign in_stall_o = (state_q != SIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SCheck;
        end
      end
      SCheck: begin
        if (!status_i.held_valid) begin
          // A move with nothing held is just stored; an end item is dropped.
          cmd_o.load_first = !status_i.is_end;
          state_d          = SIdle;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = SAxis;
        end
      end
      SAxis: begin
        if (status_i.hit && !status_i.sat) begin
          cmd_o.div_load = 1'b1;
          state_d        = SDiv;
        end else begin
          // A saturated quotient never lowers the speed.
          cmd_o.axis_next = 1'b1;
          if (status_i.axis_last) begin
            state_d = SDone;
          end
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = SApply;
        end
      end
      SApply: begin
        cmd_o.apply_q   = 1'b1;
        cmd_o.axis_next = 1'b1;
        state_d         = status_i.axis_last ? SDone : SAxis;
      end
      SDone: begin
        if (!status_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cjvl_dp.sv =====
// Datapath for the corner junction velocity limit block: configuration,
// held move, per-axis delta, shared bit-serial divider and output register.
// Depends on cjvl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cjvl_dp #(
  parameter int NUM_AXES = cjvl_pkg::NumAxes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [cjvl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cjvl_pkg::CfgDataW-1:0]     cfg_data_i,
  input  cjvl_pkg::in_item_t                in_item_i,
  output cjvl_pkg::out_item_t               out_item_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  cjvl_pkg::cmd_t                    cmd_i,
  output cjvl_pkg::status_t                 status_o
);

  localparam int AxW    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int UnitW  = cjvl_pkg::UnitW;
  localparam int LenW   = cjvl_pkg::LenW;
  localparam int SpeedW = cjvl_pkg::SpeedW;
  localparam int LimitW = cjvl_pkg::LimitW;
  localparam int QW     = SpeedW;
  localparam int CntW   = $clog2(QW);

  // Configuration registers.
  logic [LimitW-1:0] limit_q [NUM_AXES];
  logic [LenW-1:0]   window_q;
  logic [UnitW-1:0]  floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        limit_q[i] <= '0;
      end
      window_q <= cjvl_pkg::WindowReset;
      floor_q  <= cjvl_pkg::FloorReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cjvl_pkg::CfgWindow) begin
        window_q <= cfg_data_i[LenW-1:0];
      end else if (cfg_index_i == cjvl_pkg::CfgFloor) begin
        floor_q <= cfg_data_i[UnitW-1:0];
      end else if (int'(cfg_index_i) < NUM_AXES) begin
        limit_q[cfg_index_i[AxW-1:0]] <= cfg_data_i[LimitW-1:0];
      end
    end
  end

  // Captured input item.
  cjvl_pkg::in_item_t cap_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cap_q <= in_item_i;
    end
  end

  logic signed [UnitW-1:0] cap_unit [6];
  assign cap_unit[0] = cap_q.unit_x;
  assign cap_unit[1] = cap_q.unit_y;
  assign cap_unit[2] = cap_q.unit_z;
  assign cap_unit[3] = cap_q.unit_a;
  assign cap_unit[4] = cap_q.unit_b;
  assign cap_unit[5] = cap_q.unit_c;

  // Held move state.
  logic                    held_valid_q;
  logic signed [UnitW-1:0] held_unit_q    [NUM_AXES];
  logic signed [UnitW-1:0] held_carried_q [NUM_AXES];
  logic [5:0]              held_mask_q;
  logic [LenW-1:0]         held_length_q;
  logic [SpeedW-1:0]       held_vmax_q;
  logic [LenW-1:0]         held_since_q;

  // Short move window decision.
  logic [LenW:0] len_sum;
  logic          use_carried;
  assign len_sum     = {1'b0, held_since_q} + {1'b0, held_length_q};
  assign use_carried = len_sum < {1'b0, window_q};

  // Carried unit for the next hold, per axis.
  logic signed [UnitW-1:0] next_carried [NUM_AXES];
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (held_mask_q[i] || cap_q.axis_mask[i]) begin
        next_carried[i] = use_carried ? held_carried_q[i] : held_unit_q[i];
      end else begin
        next_carried[i] = '0;
      end
    end
  end

  // Axis sequencing and running speed limit.
  logic [AxW-1:0]    axis_q;
  logic [SpeedW-1:0] v_q;

  // Delta of the current axis.
  logic signed [UnitW-1:0] hu, hc, nu;
  logic signed [UnitW:0]   diff_h, diff_c;
  logic [UnitW-1:0]        abs_h, abs_c, delta;
  logic                    axis_en;
  logic [LimitW-1:0]       cur_limit;

  always_comb begin
    hu     = held_unit_q[axis_q];
    hc     = held_carried_q[axis_q];
    nu     = cap_unit[3'(axis_q)];
    diff_h = {hu[UnitW-1], hu} - {nu[UnitW-1], nu};
    diff_c = {hc[UnitW-1], hc} - {nu[UnitW-1], nu};
    abs_h  = diff_h[UnitW] ? UnitW'(-diff_h) : diff_h[UnitW-1:0];
    abs_c  = diff_c[UnitW] ? UnitW'(-diff_c) : diff_c[UnitW-1:0];
    cur_limit = limit_q[axis_q];
    if (cap_q.op == cjvl_pkg::OpEnd) begin
      // Stop case: only a positive component of the held move counts.
      axis_en = held_mask_q[3'(axis_q)];
      delta   = hu[UnitW-1] ? '0 : hu;
    end else begin
      axis_en = held_mask_q[3'(axis_q)] || cap_q.axis_mask[3'(axis_q)];
      delta   = (use_carried && (abs_c > abs_h)) ? abs_c : abs_h;
    end
  end

  // Quotient saturates when limit * 2^15 >= delta * 2^32.
  logic hit, sat;
  assign hit = axis_en && (delta > floor_q);
  assign sat = cur_limit >= (LimitW'(delta) << (QW - 15));

  // Restoring divider, one quotient bit per cycle.
  logic [UnitW-1:0] rem_q;
  logic [UnitW-1:0] dsr_q;
  logic [QW-1:0]    sh_q;
  logic [CntW-1:0]  cnt_q;
  logic [UnitW:0]   trial;
  logic             ge;

  assign trial = {rem_q, sh_q[QW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      // Upper part of the shifted dividend is known to be below the divisor.
      rem_q <= UnitW'(cur_limit >> (QW - 15));
      sh_q  <= {cur_limit[QW-16:0], 15'b0};
      dsr_q <= delta;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? UnitW'(trial - {1'b0, dsr_q}) : trial[UnitW-1:0];
      sh_q  <= {sh_q[QW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Running limit and axis counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      axis_q <= '0;
      if (cap_q.op == cjvl_pkg::OpEnd || held_vmax_q < cap_q.abs_vmax) begin
        v_q <= held_vmax_q;
      end else begin
        v_q <= cap_q.abs_vmax;
      end
    end else begin
      if (cmd_i.apply_q && (sh_q < v_q)) begin
        v_q <= sh_q;
      end
      if (cmd_i.axis_next) begin
        axis_q <= axis_q + 1'b1;
      end
    end
  end

  // Held move update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q  <= 1'b0;
      held_mask_q   <= '0;
      held_length_q <= '0;
      held_vmax_q   <= '0;
      held_since_q  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        held_unit_q[i]    <= '0;
        held_carried_q[i] <= '0;
      end
    end else if (cmd_i.load_first ||
                 (cmd_i.commit && cap_q.op == cjvl_pkg::OpMove)) begin
      held_valid_q  <= 1'b1;
      held_mask_q   <= cap_q.axis_mask;
      held_length_q <= cap_q.move_length;
      held_vmax_q   <= cap_q.abs_vmax;
      if (cmd_i.load_first) begin
        held_since_q <= '0;
      end else begin
        held_since_q <= use_carried ? len_sum[LenW-1:0] : held_length_q;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        held_unit_q[i]    <= cap_unit[i];
        held_carried_q[i] <= cmd_i.load_first ? '0 : next_carried[i];
      end
    end else if (cmd_i.commit) begin
      // End item: the hold returns to its reset contents.
      held_valid_q  <= 1'b0;
      held_mask_q   <= '0;
      held_length_q <= '0;
      held_vmax_q   <= '0;
      held_since_q  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        held_unit_q[i]    <= '0;
        held_carried_q[i] <= '0;
      end
    end
  end

  // Output register.
  logic                out_valid_q;
  cjvl_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.corner_speed <= v_q;
      out_q.to_stop      <= cap_q.op;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status to the controller.
  always_comb begin
    status_o.held_valid  = held_valid_q;
    status_o.is_end      = (cap_q.op == cjvl_pkg::OpEnd);
    status_o.hit         = hit;
    status_o.sat         = sat;
    status_o.div_last    = (cnt_q == CntW'(QW - 1));
    status_o.axis_last   = (int'(axis_q) == NUM_AXES - 1);
    status_o.out_blocked = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/corner_junction_velocity_limit_core.sv =====
// Corner junction velocity limit: holds the last planned move and, when the
// next move or an end item arrives, delivers the held move's corner speed.
// Each axis is evaluated in turn; each axis whose delta limits the speed without
// saturating goes through one shared divider, which produces a 32-bit quotient
// one bit per cycle. A new item is not taken until the last one is committed.
// A move arriving with nothing held is stored with no result. Configuration
// is always ready. Depends on cjvl_pkg, cjvl_ctrl and cjvl_dp.
`timescale 1ns / 1ps
`default_nettype none

module corner_junction_velocity_limit_core #(
  parameter int NUM_AXES = cjvl_pkg::NumAxes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cjvl_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cjvl_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cjvl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cjvl_pkg::CfgDataW-1:0] cfg_data_i
);

  cjvl_pkg::cmd_t    cmd;
  cjvl_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  cjvl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  cjvl_dp #(
    .NUM_AXES (NUM_AXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// ===== tb/corner_junction_velocity_limit_core_tb.sv =====
// Self-checking testbench for corner_junction_velocity_limit_core.
// Directed tables and random move sequences are checked against a corner speed predictor, but for
// fixed expected speeds in part of the first table; depends on cjvl_pkg and the core RTL.
`timescale 1ns / 1ps

module corner_junction_velocity_limit_core_tb;
  import cjvl_pkg::*;

  localparam int SettleCycles = 250;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the configuration and of the held move.
  logic [LimitW-1:0] corner_lim[NumAxes];
  logic [LenW-1:0] window_reg;
  logic [UnitW-1:0] floor_reg;
  bit held_valid;
  logic signed [UnitW-1:0] held_u[NumAxes];
  logic signed [UnitW-1:0] held_carried[NumAxes];
  logic [5:0] held_mask;
  logic [LenW-1:0] held_len, held_since;
  logic [SpeedW-1:0] held_vmax;

  out_item_t speed_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  row_t rows[$];

  corner_junction_velocity_limit_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_hold();
    held_valid = 1'b0;
    held_mask = '0;
    held_len = '0;
    held_since = '0;
    held_vmax = '0;
    for (int i = 0; i < NumAxes; i++) begin
      held_u[i] = '0;
      held_carried[i] = '0;
    end
  endfunction

  // Lower the speed to limit * 2^15 / delta, saturated to 32 bits.
  function automatic logic [SpeedW-1:0] cap_speed(int axis, logic [31:0] d,
                                                  logic [SpeedW-1:0] v);
    logic [63:0] q;
    q = {1'b0, corner_lim[axis], 15'b0} / {32'b0, d};
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return (q[31:0] < v) ? q[31:0] : v;
  endfunction

  // Corner speed predictor; returns 1 when the item produces a result.
  function automatic bit predict_corner(in_item_t it, output out_item_t res);
    int u[NumAxes];
    int diff;
    int cdiff;
    logic [31:0] d;
    logic [31:0] cd;
    logic [SpeedW-1:0] v;
    logic [63:0] sum;
    bit use_c;
    logic signed [UnitW-1:0] nc[NumAxes];
    logic [LenW-1:0] nsince;
    res = '0;
    u[0] = it.unit_x; u[1] = it.unit_y; u[2] = it.unit_z;
    u[3] = it.unit_a; u[4] = it.unit_b; u[5] = it.unit_c;
    if (it.op == OpEnd) begin
      if (!held_valid) return 1'b0;
      v = held_vmax;
      // A junction to a stop uses the held component itself as delta, only where it is positive.
      for (int i = 0; i < NumAxes; i++) begin
        if (held_mask[i] && held_u[i] > 0 && 32'(held_u[i]) > {16'b0, floor_reg})
          v = cap_speed(i, 32'(held_u[i]), v);
      end
      res.corner_speed = v;
      res.to_stop = 1'b1;
      clear_hold();
      return 1'b1;
    end
    if (!held_valid) begin
      clear_hold();
      held_valid = 1'b1;
      for (int i = 0; i < NumAxes; i++) held_u[i] = u[i][15:0];
      held_mask = it.axis_mask;
      held_len = it.move_length;
      held_vmax = it.abs_vmax;
      return 1'b0;
    end
    sum = 64'(held_since) + 64'(held_len);
    use_c = sum < {32'b0, window_reg};
    nsince = use_c ? sum[31:0] : held_len;
    v = (held_vmax < it.abs_vmax) ? held_vmax : it.abs_vmax;
    for (int i = 0; i < NumAxes; i++) begin
      nc[i] = '0;
      if (held_mask[i] || it.axis_mask[i]) begin
        diff = int'(held_u[i]) - u[i];
        d = (diff < 0) ? -diff : diff;
        if (use_c) begin
          // Over short moves the carried unit vector may give a sharper corner.
          cdiff = int'(held_carried[i]) - u[i];
          cd = (cdiff < 0) ? -cdiff : cdiff;
          if (cd > d) d = cd;
          nc[i] = held_carried[i];
        end else begin
          nc[i] = held_u[i];
        end
        if (d > {16'b0, floor_reg}) v = cap_speed(i, d, v);
      end
    end
    res.corner_speed = v;
    res.to_stop = 1'b0;
    for (int i = 0; i < NumAxes; i++) begin
      held_u[i] = u[i][15:0];
      held_carried[i] = nc[i];
    end
    held_mask = it.axis_mask;
    held_len = it.move_length;
    held_vmax = it.abs_vmax;
    held_since = nsince;
    return 1'b1;
  endfunction

  function automatic in_item_t make_item(logic op, int ux, int uy, int uz, int ua, int ub,
                                         int uc, logic [5:0] mask, logic [31:0] len,
                                         logic [31:0] vmax);
    in_item_t it;
    it.op = op;
    it.unit_x = ux[15:0]; it.unit_y = uy[15:0]; it.unit_z = uz[15:0];
    it.unit_a = ua[15:0]; it.unit_b = ub[15:0]; it.unit_c = uc[15:0];
    it.axis_mask = mask;
    it.move_length = len;
    it.abs_vmax = vmax;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, logic [31:0] speed,
                                  logic stop);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want.corner_speed = speed;
    r.want.to_stop = stop;
    rows.push_back(r);
  endfunction

  // Random unit component: full range half the time, else a fixed edge value or near the last.
  function automatic int pick_unit(int last);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return 1;
        endcase
      end
      2: return last + $urandom_range(0, 400) - 200;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic logic [47:0] pick_limit();
    logic [47:0] x;
    x = 48'({$urandom(), $urandom()});
    return x >> $urandom_range(0, 40);
  endfunction

  // Configuration write; the port accepts on valid and ready.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx <= CfgLimitC) corner_lim[idx] = data;
    else if (idx == CfgWindow) window_reg = data[31:0];
    else if (idx == CfgFloor) floor_reg = data[15:0];
  endtask

  task automatic write_all(logic [47:0] lx, logic [47:0] ly, logic [47:0] lz,
                           logic [47:0] la, logic [47:0] lb, logic [47:0] lc,
                           logic [31:0] win, logic [15:0] flr);
    write_reg(CfgLimitX, lx);
    write_reg(CfgLimitY, ly);
    write_reg(CfgLimitZ, lz);
    write_reg(CfgLimitA, la);
    write_reg(CfgLimitB, lb);
    write_reg(CfgLimitC, lc);
    write_reg(CfgWindow, {16'b0, win});
    write_reg(CfgFloor, {32'b0, flr});
  endtask

  task automatic wait_results();
    while (speed_q.size() != 0) @(posedge clk);
  endtask

  // Block is idle once all speeds are in and a held-only move has settled.
  task automatic wait_idle();
    wait_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Offer one item, wait for the transfer, record its expected speed.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_corner(it, pred)) speed_q.push_back(typed ? want : pred);
    if (!quiet && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Receiver stalls at random except during the quiet stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 36);
    end
  end

  // Compare each result transfer with the oldest expected speed.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (speed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: vmax %h stop %b",
                                   out_item.corner_speed, out_item.to_stop);
      end else begin
        out_item_t w;
        w = speed_q.pop_front();
        if (out_item.corner_speed !== w.corner_speed || out_item.to_stop !== w.to_stop) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected vmax %h stop %b, got vmax %h stop %b",
                                     w.corner_speed, w.to_stop,
                                     out_item.corner_speed, out_item.to_stop);
        end
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t none;
    int lu[NumAxes];
    int u[NumAxes];
    none = '0;
    for (int i = 0; i < NumAxes; i++) begin
      corner_lim[i] = '0;
      lu[i] = 0;
    end
    window_reg = WindowReset;
    floor_reg = FloorReset;
    clear_hold();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: every limit is zero, so any limiting axis gives zero.
    add_row(make_item(OpEnd, 5, 5, 5, 5, 5, 5, 6'h3F, 1, 1), 0, 0, 0);
    add_row(make_item(OpMove, 32767, 0, 0, 0, 0, 0, 6'h01, 32'h10000, 32'h50000), 0, 0, 0);
    add_row(make_item(OpMove, 32767, 0, 0, 0, 0, 0, 6'h01, 32'h10000, 32'h30000),
            1, 32'h30000, 1'b0);
    add_row(make_item(OpMove, -32768, 0, 0, 0, 0, 0, 6'h01, 32'h10000, 32'hFFFF_FFFF),
            1, 32'h0, 1'b0);
    add_row(make_item(OpEnd, 0, 0, 0, 0, 0, 0, 6'h00, 0, 0), 1, 32'hFFFF_FFFF, 1'b1);
    foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].want);
    in_valid <= 1'b0;
    wait_idle();

    // Directed extremes under a mixed configuration, checked by the predictor.
    write_all(48'hFFFF_FFFF_FFFF, 48'h1, 48'h1_0000, pick_limit(), 48'h8000_0000_0000,
              48'h3FFF, 32'h20000, 16'd100);
    rows.delete();
    add_row(make_item(OpMove, 32767, 32767, 32767, 32767, 32767, 32767, 6'h3F, 0,
                      32'hFFFF_FFFF), 0, 0, 0);
    add_row(make_item(OpMove, -32768, -32768, -32768, -32768, -32768, -32768, 6'h3F, 0,
                      32'hFFFF_FFFF), 0, 0, 0);
    add_row(make_item(OpMove, 0, 0, 0, 0, 0, 0, 6'h00, 32'h1000, 32'h1234_5678), 0, 0, 0);
    add_row(make_item(OpMove, 100, -100, 20000, -20000, 32767, -1, 6'h2A, 32'hFFFF_FFFF, 0),
            0, 0, 0);
    add_row(make_item(OpMove, 50, 0, 0, 0, 0, 0, 6'h01, 32'h100, 32'h7FFF_FFFF), 0, 0, 0);
    add_row(make_item(OpMove, 150, 0, 0, 0, 0, 0, 6'h01, 32'h4000, 32'h8000_0000), 0, 0, 0);
    add_row(make_item(OpMove, 23170, 23170, 0, 0, 0, 0, 6'h03, 32'h4000, 32'h10_0000), 0, 0, 0);
    add_row(make_item(OpMove, 0, 32767, 0, 0, 0, 0, 6'h02, 32'h4000, 32'h10_0000), 0, 0, 0);
    add_row(make_item(OpMove, -23170, 23170, 0, 0, 0, 0, 6'h03, 32'h4000, 32'h10_0000), 0, 0, 0);
    add_row(make_item(OpEnd, -5, 7, 9, 11, 13, 15, 6'h15, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            0, 0, 0);
    add_row(make_item(OpEnd, 0, 0, 0, 0, 0, 0, 6'h3F, 0, 0), 0, 0, 0);
    add_row(make_item(OpMove, 32767, 200, 300, 400, 500, 32767, 6'h3F, 32'h8000, 32'hFFFF),
            0, 0, 0);
    add_row(make_item(OpEnd, 0, 0, 0, 0, 0, 0, 6'h00, 0, 0), 0, 0, 0);
    foreach (rows[k]) send_item(rows[k].item, 0, none);
    in_valid <= 1'b0;

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        1: write_all('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, 16'd0);
        2: write_all('0, '0, '0, '0, '0, '0, 32'd0, 16'hFFFF);
        default: write_all(pick_limit(), pick_limit(), pick_limit(), pick_limit(),
                           pick_limit(), pick_limit(), $urandom_range(0, 32'h40000),
                           16'($urandom_range(0, 300)));
      endcase
      quiet = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 50) begin
          in_valid <= 1'b0;
          wait_results();
        end
        for (int i = 0; i < NumAxes; i++) begin
          u[i] = pick_unit(lu[i]);
          lu[i] = u[i];
        end
        it = make_item(($urandom_range(0, 99) < 10) ? OpEnd : OpMove,
                       u[0], u[1], u[2], u[3], u[4], u[5], 6'($urandom_range(0, 63)),
                       ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32'h18000) : $urandom(),
                       $urandom());
        send_item(it, 0, none);
      end
      in_valid <= 1'b0;
    end
    quiet = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
